// File: sv/udiv_pkg.sv
`timescale 1ns / 1ps

package udiv_pkg;

  // width of each operand and result field on the stream ports
  localparam int unsigned FIELD_WIDTH = 64;

  // default operand width used inside the cell chain
  localparam int unsigned DATA_WIDTH_DEFAULT = 64;

  // stream layouts: two fields packed from the lowest bit up
  localparam int unsigned S_TDATA_WIDTH = 2 * FIELD_WIDTH;
  localparam int unsigned M_TDATA_WIDTH = 2 * FIELD_WIDTH;
  localparam int unsigned M_TUSER_WIDTH = 1;

endpackage

// File: sv/udiv_cell.sv
`timescale 1ns / 1ps

module udiv_cell #(
  parameter int unsigned W = udiv_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] num_in,
  input  logic [W-1:0] den_in,
  input  logic [W-1:0] rem_in,
  input  logic [W-1:0] quo_in,
  input  logic         dz_in,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] num_out,
  output logic [W-1:0] den_out,
  output logic [W-1:0] rem_out,
  output logic [W-1:0] quo_out,
  output logic         dz_out
);

  import udiv_pkg::*;

  logic         valid;
  logic [W-1:0] num;
  logic [W-1:0] den;
  logic [W-1:0] rem;
  logic [W-1:0] quo;
  logic         dz;

  logic [W-1:0] shifted;
  logic [W:0]   wide;
  logic [W:0]   diff;
  logic         take;
  logic [W-1:0] rem_next;
  logic [W-1:0] quo_next;
  logic [W-1:0] num_next;

  // one restoring step: shift in the next numerator bit, keep the carry out
  always_comb begin
    shifted  = {rem_in[W-2:0], num_in[W-1]};
    wide     = {rem_in[W-1], shifted};
    diff     = wide - {1'b0, den_in};
    take     = ~diff[W];
    rem_next = take ? diff[W-1:0] : shifted;
    quo_next = {quo_in[W-2:0], take};
    num_next = {num_in[W-2:0], 1'b0};
  end

  assign in_ready = ~valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      num <= num_next;
      den <= den_in;
      rem <= rem_next;
      quo <= quo_next;
      dz  <= dz_in;
    end
  end

  assign out_valid = valid;
  assign num_out   = num;
  assign den_out   = den;
  assign rem_out   = rem;
  assign quo_out   = quo;
  assign dz_out    = dz;

endmodule

// File: sv/unsigned_divide_64.sv
`timescale 1ns / 1ps

// channel   dir  handshake                     payload (lowest bit first)
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: dividend[63:0], divisor_value[63:0]
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: quotient[63:0], remainder_out[63:0]
//                                              tuser: divide_by_zero
//
// one request enters per cycle while s_axis_tready is high; each result passes through
// one restoring subtract cell per quotient bit, in a chain of DATA_WIDTH cells.
// the last cell is the output register; a stalled output only stops the cells
// behind it until the first empty cell, so requests keep entering into bubbles.
// rst (synchronous) empties every cell; no request is pending after reset.

module unsigned_divide_64 #(
  parameter int unsigned DATA_WIDTH = udiv_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // dividend, divisor_value
  input  logic [udiv_pkg::S_TDATA_WIDTH-1:0] s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // quotient, remainder_out
  output logic [udiv_pkg::M_TDATA_WIDTH-1:0] m_axis_tdata,
  // divide_by_zero
  output logic [udiv_pkg::M_TUSER_WIDTH-1:0] m_axis_tuser
);

  import udiv_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  logic         valid [W+1];
  logic         ready [W+1];
  logic [W-1:0] num   [W+1];
  logic [W-1:0] den   [W+1];
  logic [W-1:0] rem   [W+1];
  logic [W-1:0] quo   [W+1];
  logic         dz    [W+1];

  logic [W-1:0] quo_final;
  logic [W-1:0] rem_final;

  // operand bits above DATA_WIDTH are ignored
  assign valid[0]      = s_axis_tvalid;
  assign s_axis_tready = ready[0];
  assign num[0]        = s_axis_tdata[W-1:0];
  assign den[0]        = s_axis_tdata[FIELD_WIDTH +: W];
  assign rem[0]        = '0;
  assign quo[0]        = '0;
  assign dz[0]         = (s_axis_tdata[FIELD_WIDTH +: W] == '0);

  for (genvar k = 0; k < W; k++) begin : g_cell
    udiv_cell #(
      .W (W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[k]),
      .in_ready  (ready[k]),
      .num_in    (num[k]),
      .den_in    (den[k]),
      .rem_in    (rem[k]),
      .quo_in    (quo[k]),
      .dz_in     (dz[k]),
      .out_valid (valid[k+1]),
      .out_ready (ready[k+1]),
      .num_out   (num[k+1]),
      .den_out   (den[k+1]),
      .rem_out   (rem[k+1]),
      .quo_out   (quo[k+1]),
      .dz_out    (dz[k+1])
    );
  end

  assign ready[W] = m_axis_tready;

  // zero divisor: all-ones quotient, zero remainder
  always_comb begin
    quo_final = dz[W] ? '1 : quo[W];
    rem_final = dz[W] ? '0 : rem[W];
  end

  assign m_axis_tvalid = valid[W];
  assign m_axis_tdata  = {FIELD_WIDTH'(rem_final), FIELD_WIDTH'(quo_final)};
  assign m_axis_tuser  = M_TUSER_WIDTH'(dz[W]);

endmodule

// File: sv/udiv_checker.sv
`timescale 1ns / 1ps

module udiv_checker #(
  parameter int unsigned DATA_WIDTH = udiv_pkg::DATA_WIDTH_DEFAULT
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [udiv_pkg::S_TDATA_WIDTH-1:0] s_axis_tdata,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [udiv_pkg::M_TDATA_WIDTH-1:0] m_axis_tdata,
  input logic [udiv_pkg::M_TUSER_WIDTH-1:0] m_axis_tuser
);

  import udiv_pkg::*;

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // reset empties the chain and opens the input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("chain not empty after reset");

  // the input only closes when every cell is full and the output is stalled
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input blocked while output moves");

  // zero-divisor results carry the fixed pattern
  a_dz_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[DATA_WIDTH-1:0] == '1 &&
      m_axis_tdata[FIELD_WIDTH +: FIELD_WIDTH] == '0)
    else $error("bad zero-divisor result");

  // a waiting request stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("request changed while stalled");

endmodule

bind unsigned_divide_64 udiv_checker #(.DATA_WIDTH(DATA_WIDTH)) u_udiv_checker (.*);
